// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; they expand to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property that is switched off while the reset is asserted.
`define BSA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed in %m");
// Clocked property that also holds while the reset is asserted.
`define BSA_ASSERT_NORST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed in %m");
`else
`define BSA_ASSERT(lbl, clk, rst_n, prop)
`define BSA_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// ===== sv/bsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounce slot allocator package
// Field widths, status codes and sequencer state types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsa_pkg;

    localparam int REQ_BYTES_W = 19;
    localparam int SLOT_W      = 12;
    localparam int STATUS_W    = 2;
    localparam int CFG_W       = 13;

    localparam logic [CFG_W-1:0] SLOTS_IN_USE_RST = 13'd4096;

    localparam logic KIND_ALLOC = 1'b0;

    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 2'd2;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_MOD,
        S_POOL,
        S_DISPATCH,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_ZERO,
        S_RN_BASE,
        S_FREE_SETUP,
        S_FREE_RD,
        S_FREE_WR,
        S_RN_RD,
        S_RN_CHK,
        S_REPLY
    } t_state;

    // Which job the shared reduction unit is doing.
    typedef enum logic [1:0] {
        MOD_POOL,
        MOD_SLOT,
        MOD_RUN
    } t_mod_use;

endpackage

// ===== sv/bsa_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Carries one allocate or free word with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bsa_req_if import bsa_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic [REQ_BYTES_W-1:0] request_bytes;
    logic [SLOT_W-1:0]      free_slot;

    modport source (output valid, output kind, output request_bytes, output free_slot,
                    input ready);
    modport sink   (input valid, input kind, input request_bytes, input free_slot,
                    output ready);
endinterface

// ===== sv/bsa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Carries one result word with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bsa_rsp_if import bsa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   first_slot;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output first_slot, output status, input ready);
    modport sink   (input valid, input first_slot, input status, output ready);
endinterface

// ===== sv/bsa_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration channel
// Carries a write word for the slots-in-use register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bsa_cfg_if import bsa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] slots_in_use;

    modport source (output valid, output slots_in_use, input ready);
    modport sink   (input valid, input slots_in_use, output ready);
endinterface

// ===== sv/bsa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/bounce_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// Bounce slot allocator
// Allocates and frees runs of fixed-size slots held in segments, keeping for
// every slot the length of the free run that starts there.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Word
// i_req     in         kind, request_bytes, free_slot
// o_rsp     out        first_slot, status
// i_cfg     in         slots_in_use
//
// After reset the block sweeps the run-length RAM once, one entry per cycle,
// writing the initial run lengths for all MAX_SLOTS entries (4096 by
// default), and no request is taken meanwhile. Configuration writes are
// always taken.
// A request is processed by a small sequencer around one reciprocal-multiply
// reduction unit and the single-port-per-direction run-length RAM, one word
// at a time. The reduction forms the quotient and then the
// remainder. An allocate probes candidate slots, zeroes the run that it
// takes and renumbers the free slots in front of it. A free rewrites the
// run lengths of the freed run and renumbers the free slots in front of it.
// The result sits in an output register; when it is stalled the sequencer
// waits before loading the next one.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bounce_slot_allocator
    import bsa_pkg::*;
#(
    parameter int MAX_SLOTS     = 4096,
    parameter int SEGMENT_SLOTS = 128,
    parameter int SLOT_SHIFT    = 11,
    parameter int PAGE_BITS     = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsa_req_if.sink   i_req,
    bsa_rsp_if.source o_rsp,
    bsa_cfg_if.sink   i_cfg
);

    // Slot index into the RAM, pool size, run-length value and offset within a segment.
    localparam int IW         = $clog2(MAX_SLOTS);
    localparam int XW         = $clog2(MAX_SLOTS + 1);
    localparam int CW         = $clog2(SEGMENT_SLOTS + 1);
    localparam int OW         = $clog2(SEGMENT_SLOTS);
    localparam int KW         = 1;
    localparam int MOD_STEPS  = 2;
    localparam int RB1        = REQ_BYTES_W + 1;
    localparam int NEED_W     = RB1 - SLOT_SHIFT;
    localparam int MAX_STRIDE = (PAGE_BITS > SLOT_SHIFT) ? (1 << (PAGE_BITS - SLOT_SHIFT)) : 1;
    // Wide enough for any index plus a stride, a run or a rounded start.
    localparam int SUM_W = $clog2(MAX_SLOTS + SEGMENT_SLOTS + MAX_STRIDE + (1 << SLOT_W)) + 1;
    // Reciprocal of the segment size, rounded up, so that the quotient of
    // any XW-bit value is exact after the shift.
    localparam int MOD_SH = XW + $clog2(SEGMENT_SLOTS);
    localparam int PW     = 2 * XW + 1;
    localparam logic [PW-1:0] MOD_M =
        PW'(((64'd1 << MOD_SH) + 64'(SEGMENT_SLOTS) - 64'd1) / 64'(SEGMENT_SLOTS));

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    t_state               r_state, n_state;
    t_mod_use             r_mod_use, n_mod_use;
    logic [KW-1:0]        r_kstep, n_kstep;
    logic [XW-1:0]        r_rem, n_rem;
    logic [XW-1:0]        r_quo, n_quo;
    logic [XW-1:0]        r_n, n_n;
    logic                 r_kind, n_kind;
    logic [REQ_BYTES_W-1:0] r_bytes, n_bytes;
    logic [SUM_W-1:0]     r_slot, n_slot;
    logic [NEED_W-1:0]    r_need, n_need;
    logic [SUM_W-1:0]     r_idx, n_idx;
    logic [SUM_W-1:0]     r_wrap, n_wrap;
    logic [SUM_W-1:0]     r_cur, n_cur;
    logic [SUM_W-1:0]     r_base, n_base;
    logic [CW-1:0]        r_left, n_left;
    logic [CW-1:0]        r_count, n_count;
    logic [SLOT_W-1:0]    r_search_start, n_search_start;
    logic [CFG_W-1:0]     r_slots_in_use;
    logic [SLOT_W-1:0]    r_res_first, n_res_first;
    logic [STATUS_W-1:0]  r_res_status, n_res_status;
    logic [IW-1:0]        r_init_addr, n_init_addr;
    logic [OW-1:0]        r_init_off, n_init_off;
    logic                 r_out_valid;
    logic [SLOT_W-1:0]    r_first;
    logic [STATUS_W-1:0]  r_status;

    // RAM port signals.
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [CW-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [CW-1:0] ram_rdata;
    logic          req_ready;

    bsa_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_SLOTS)
    ) u_run_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // Shared reduction unit: x mod SEGMENT_SLOTS. It first forms the quotient by
    // multiplying with the rounded-up reciprocal, then subtracts quotient times
    // segment size.
    // ------------------------------------------------------------------------
    logic [PW-1:0] mod_prod;
    logic [XW-1:0] mod_quo;
    logic [XW-1:0] mod_sub;
    logic          mod_last;

    assign mod_prod = PW'(r_rem) * MOD_M;
    assign mod_quo  = XW'(mod_prod >> MOD_SH);
    assign mod_sub  = r_rem - XW'(r_quo * XW'(SEGMENT_SLOTS));
    assign mod_last = (r_kstep == '0);

    // ------------------------------------------------------------------------
    // Request decode and loop conditions
    // ------------------------------------------------------------------------
    logic [XW-1:0]     pool_x;
    logic [RB1-1:0]    bytes_up;
    logic [NEED_W-1:0] need_in;
    logic              page_req;
    logic [SUM_W-1:0]  stride;
    logic [SUM_W-1:0]  rounded;
    logic [SUM_W-1:0]  start_idx;
    logic              alloc_reject;
    logic              free_oor;
    logic              probe_hit;
    logic [SUM_W-1:0]  idx_step;
    logic [SUM_W-1:0]  next_idx;
    logic              probe_wrap;
    logic [SUM_W-1:0]  idx_need;
    logic              zero_last;
    logic [SUM_W-1:0]  slot_base;
    logic [SUM_W-1:0]  seg_end;
    logic [SUM_W-1:0]  room;
    logic [SUM_W-1:0]  free_end;
    logic              end_inside;
    logic              fw_more;
    logic [SUM_W-1:0]  cur_m1;
    logic              rn_done;
    logic              rn_free;
    logic              out_free;
    logic              init_last;

    // The register is clipped to the RAM size; the reduction rounds it down.
    assign pool_x = (32'(r_slots_in_use) > 32'(MAX_SLOTS)) ? XW'(MAX_SLOTS)
                                                           : XW'(r_slots_in_use);

    assign bytes_up = {1'b0, i_req.request_bytes} + RB1'((1 << SLOT_SHIFT) - 1);
    assign need_in  = NEED_W'(bytes_up >> SLOT_SHIFT);

    // Requests larger than a page are placed on page boundaries.
    assign page_req = 32'(r_bytes) > (32'd1 << PAGE_BITS);
    assign stride   = page_req ? SUM_W'(MAX_STRIDE) : SUM_W'(1);
    assign rounded  = (SUM_W'(r_search_start) + stride - SUM_W'(1)) & ~(stride - SUM_W'(1));
    assign start_idx = (rounded >= SUM_W'(r_n)) ? '0 : rounded;

    assign alloc_reject = (r_need == '0) || (r_n == '0)
                          || (32'(r_need) > 32'(SEGMENT_SLOTS));
    assign free_oor     = r_slot >= SUM_W'(r_n);

    assign probe_hit  = 32'(ram_rdata) >= 32'(r_need);
    assign idx_step   = r_idx + stride;
    assign next_idx   = (idx_step >= SUM_W'(r_n)) ? '0 : idx_step;
    assign probe_wrap = (next_idx == r_wrap);
    assign idx_need   = r_idx + SUM_W'(r_need);
    assign zero_last  = (r_left == CW'(1));

    // A freed run is clipped at the end of its segment.
    assign slot_base  = r_slot - SUM_W'(r_rem);
    assign seg_end    = slot_base + SUM_W'(SEGMENT_SLOTS);
    assign room       = seg_end - r_slot;
    assign free_end   = (32'(r_need) > 32'(room)) ? seg_end : (r_slot + SUM_W'(r_need));
    assign end_inside = free_end < seg_end;
    assign fw_more    = r_cur > r_slot;

    assign cur_m1  = r_cur - SUM_W'(1);
    assign rn_done = (r_cur == r_base);
    assign rn_free = (ram_rdata != '0);

    assign out_free  = !r_out_valid || o_rsp.ready;
    assign init_last = (r_init_addr == IW'(MAX_SLOTS - 1));

    // ------------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (mod_last) begin
                    unique case (r_mod_use)
                        MOD_POOL: n_state = S_POOL;
                        MOD_SLOT: n_state = S_FREE_SETUP;
                        MOD_RUN:  n_state = S_RN_BASE;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_POOL: n_state = S_DISPATCH;
            S_DISPATCH: begin
                if (r_kind == KIND_ALLOC) begin
                    n_state = alloc_reject ? S_REPLY : S_PROBE_RD;
                end else begin
                    n_state = (free_oor || (r_need == '0)) ? S_REPLY : S_MOD;
                end
            end
            S_PROBE_RD: n_state = S_PROBE_CHK;
            S_PROBE_CHK: begin
                if (probe_hit) begin
                    n_state = S_ZERO;
                end else if (probe_wrap) begin
                    n_state = S_REPLY;
                end else begin
                    n_state = S_PROBE_RD;
                end
            end
            S_ZERO: begin
                if (zero_last) begin
                    n_state = S_MOD;
                end
            end
            S_RN_BASE: n_state = S_RN_RD;
            S_FREE_SETUP: n_state = end_inside ? S_FREE_RD : S_FREE_WR;
            S_FREE_RD: n_state = S_FREE_WR;
            S_FREE_WR: begin
                if (!fw_more) begin
                    n_state = S_RN_RD;
                end
            end
            S_RN_RD: n_state = rn_done ? S_REPLY : S_RN_CHK;
            S_RN_CHK: n_state = rn_free ? S_RN_RD : S_REPLY;
            S_REPLY: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // Outputs of the sequencer: RAM port and request ready
    // ------------------------------------------------------------------------
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = IW'(r_cur);
        ram_wdata = '0;
        ram_raddr = IW'(r_idx);
        req_ready = 1'b0;
        unique case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_init_addr;
                ram_wdata = CW'(SEGMENT_SLOTS) - CW'(r_init_off);
            end
            S_IDLE: req_ready = 1'b1;
            S_ZERO: begin
                ram_we    = 1'b1;
                ram_waddr = IW'(r_cur);
                ram_wdata = '0;
            end
            S_FREE_SETUP: ram_raddr = IW'(free_end);
            S_FREE_WR: begin
                ram_we    = fw_more;
                ram_waddr = IW'(cur_m1);
                ram_wdata = r_count + CW'(1);
            end
            S_RN_RD: ram_raddr = IW'(cur_m1);
            S_RN_CHK: begin
                ram_we    = rn_free;
                ram_waddr = IW'(cur_m1);
                ram_wdata = r_count + CW'(1);
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------------
    always_comb begin
        n_mod_use      = r_mod_use;
        n_kstep        = r_kstep;
        n_rem          = r_rem;
        n_quo          = r_quo;
        n_n            = r_n;
        n_kind         = r_kind;
        n_bytes        = r_bytes;
        n_slot         = r_slot;
        n_need         = r_need;
        n_idx          = r_idx;
        n_wrap         = r_wrap;
        n_cur          = r_cur;
        n_base         = r_base;
        n_left         = r_left;
        n_count        = r_count;
        n_search_start = r_search_start;
        n_res_first    = r_res_first;
        n_res_status   = r_res_status;
        n_init_addr    = r_init_addr;
        n_init_off     = r_init_off;
        unique case (r_state)
            S_INIT: begin
                n_init_addr = r_init_addr + IW'(1);
                n_init_off  = (r_init_off == OW'(SEGMENT_SLOTS - 1)) ? '0
                                                                     : (r_init_off + OW'(1));
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_kind    = i_req.kind;
                    n_bytes   = i_req.request_bytes;
                    n_slot    = SUM_W'(i_req.free_slot);
                    n_need    = need_in;
                    n_rem     = pool_x;
                    n_n       = pool_x;
                    n_kstep   = KW'(MOD_STEPS - 1);
                    n_mod_use = MOD_POOL;
                end
            end
            S_MOD: begin
                if (mod_last) begin
                    n_rem = mod_sub;
                end else begin
                    n_quo = mod_quo;
                end
                n_kstep = r_kstep - KW'(1);
            end
            S_POOL: n_n = r_n - r_rem;
            S_DISPATCH: begin
                n_res_first  = '0;
                n_res_status = ST_NO_SPACE;
                if (r_kind == KIND_ALLOC) begin
                    n_idx  = start_idx;
                    n_wrap = start_idx;
                end else if (free_oor) begin
                    n_res_status = ST_IGNORED;
                end else begin
                    n_rem     = XW'(r_slot);
                    n_kstep   = KW'(MOD_STEPS - 1);
                    n_mod_use = MOD_SLOT;
                end
            end
            S_PROBE_CHK: begin
                if (probe_hit) begin
                    n_res_first    = SLOT_W'(r_idx);
                    n_res_status   = ST_DONE;
                    n_search_start = (idx_need < SUM_W'(r_n)) ? SLOT_W'(idx_need) : '0;
                    n_cur          = r_idx;
                    n_left         = CW'(r_need);
                end else begin
                    n_idx = next_idx;
                end
            end
            S_ZERO: begin
                n_cur  = r_cur + SUM_W'(1);
                n_left = r_left - CW'(1);
                if (zero_last) begin
                    n_rem     = XW'(r_idx);
                    n_kstep   = KW'(MOD_STEPS - 1);
                    n_mod_use = MOD_RUN;
                end
            end
            S_RN_BASE: begin
                n_base  = r_idx - SUM_W'(r_rem);
                n_cur   = r_idx;
                n_count = '0;
            end
            S_FREE_SETUP: begin
                n_base       = slot_base;
                n_cur        = free_end;
                n_count      = '0;
                n_res_status = ST_DONE;
            end
            S_FREE_RD: n_count = ram_rdata;
            S_FREE_WR: begin
                if (fw_more) begin
                    n_count = r_count + CW'(1);
                    n_cur   = cur_m1;
                end
            end
            S_RN_CHK: begin
                if (rn_free) begin
                    n_count = r_count + CW'(1);
                    n_cur   = cur_m1;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_INIT;
            r_init_addr    <= '0;
            r_init_off     <= '0;
            r_search_start <= '0;
            r_slots_in_use <= SLOTS_IN_USE_RST;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_init_addr    <= n_init_addr;
            r_init_off     <= n_init_off;
            r_search_start <= n_search_start;
            if (i_cfg.valid) begin
                r_slots_in_use <= i_cfg.slots_in_use;
            end
            if (r_state == S_REPLY && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_mod_use    <= n_mod_use;
        r_kstep      <= n_kstep;
        r_rem        <= n_rem;
        r_quo        <= n_quo;
        r_n          <= n_n;
        r_kind       <= n_kind;
        r_bytes      <= n_bytes;
        r_slot       <= n_slot;
        r_need       <= n_need;
        r_idx        <= n_idx;
        r_wrap       <= n_wrap;
        r_cur        <= n_cur;
        r_base       <= n_base;
        r_left       <= n_left;
        r_count      <= n_count;
        r_res_first  <= n_res_first;
        r_res_status <= n_res_status;
        if (r_state == S_REPLY && out_free) begin
            r_first  <= r_res_first;
            r_status <= r_res_status;
        end
    end

    // ------------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------------
    assign i_req.ready      = req_ready;
    assign i_cfg.ready      = 1'b1;
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.first_slot = r_first;
    assign o_rsp.status     = r_status;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `BSA_ASSERT(a_accept_starts_pool, i_clk, i_rst_n, (i_req.valid && i_req.ready) |=> (r_state == S_MOD && r_mod_use == MOD_POOL))
    `BSA_ASSERT(a_mod_reduced, i_clk, i_rst_n, (r_state == S_MOD && r_kstep == '0) |=> (32'(r_rem) < 32'(SEGMENT_SLOTS)))
    `BSA_ASSERT(a_run_bound, i_clk, i_rst_n, ram_we |-> (32'(ram_wdata) <= 32'(SEGMENT_SLOTS)))
    `BSA_ASSERT(a_reply_source, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_REPLY))
    `BSA_ASSERT_NORST(a_reset_clears_valid, i_clk, !i_rst_n |=> !o_rsp.valid)

endmodule
